@@ rtl/json_comment_blanker_macros.svh @@
// Assertion macros used by the top module of the comment blanker.
`ifndef JSON_COMMENT_BLANKER_MACROS_SVH
`define JSON_COMMENT_BLANKER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define JCB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define JCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jcb_pkg.sv @@
package jcb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 3;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ByteW-1:0] ChBlank  = 8'h20;
  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChHash   = 8'h23;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChNul    = 8'h00;
  localparam logic [ByteW-1:0] ChLayout = 8'd33;

  localparam logic [CodeW-1:0] CodePlain  = 3'd0;
  localparam logic [CodeW-1:0] CodeString = 3'd1;
  localparam logic [CodeW-1:0] CodeEscape = 3'd2;
  localparam logic [CodeW-1:0] CodeSlash  = 3'd3;
  localparam logic [CodeW-1:0] CodeLine   = 3'd4;
  localparam logic [CodeW-1:0] CodeBlock  = 3'd5;
  localparam logic [CodeW-1:0] CodeStar   = 3'd6;

  localparam logic [0:0] RegNulEnds = 1'b0;

  typedef enum logic [6:0] {
    S_PLAIN  = 7'b0000001,
    S_STRING = 7'b0000010,
    S_ESCAPE = 7'b0000100,
    S_SLASH  = 7'b0001000,
    S_LINE   = 7'b0010000,
    S_BLOCK  = 7'b0100000,
    S_STAR   = 7'b1000000
  } scan_state_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    scan_state_e      next_state;
  } scan_res_t;

  function automatic logic [CodeW-1:0] scan_code(scan_state_e st);
    logic [CodeW-1:0] code;
    unique case (st)
      S_STRING: code = CodeString;
      S_ESCAPE: code = CodeEscape;
      S_SLASH:  code = CodeSlash;
      S_LINE:   code = CodeLine;
      S_BLOCK:  code = CodeBlock;
      S_STAR:   code = CodeStar;
      default:  code = CodePlain;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/json_comment_blanker.sv @@
// Channel   | Direction | Beat contents
// s_t*      | in        | tdata[7:0] in_byte; tuser[0] start_of_text
// m_t*      | out       | tdata[7:0] out_byte, tdata[10:8] scan_after, rest zero
// APB       | in/out    | 0x0 nul_ends_text (bit 0)
//
// Each beat passes through the input register and then the output register,
// with the scan logic between them.
// One beat is accepted every cycle while the output side keeps up.
// The scan state advances when a beat moves into the output register.
// A stalled output holds its beat, and the input register holds one more beat.
// Reset clears the valid flags, the scan state and the configuration register.
`include "json_comment_blanker_macros.svh"

module json_comment_blanker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jcb_pkg::TdataInW-1:0]   s_tdata,  // [7:0] in_byte
  input  logic                           s_tuser,  // [0] start_of_text
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jcb_pkg::TdataOutW-1:0]  m_tdata,  // [7:0] out_byte, [10:8] scan_after
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jcb_pkg::ApbAddrW-1:0]   paddr,
  input  logic [jcb_pkg::ApbDataW-1:0]   pwdata,
  output logic [jcb_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import jcb_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic [CodeW-1:0] out_code_q;
  scan_state_e      scan_state_q;
  scan_res_t        scan_res;
  logic             nul_ends;
  logic             advance;
  logic             take;

  jcb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .nul_ends_o (nul_ends)
  );

  jcb_scan u_scan (
    .byte_i     (in_byte_q),
    .start_i    (in_start_q),
    .nul_ends_i (nul_ends),
    .state_i    (scan_state_q),
    .res_o      (scan_res)
  );

  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      scan_state_q <= S_PLAIN;
    end else begin
      if (s_tready) begin
        in_valid_q <= s_tvalid;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        scan_state_q <= scan_res.next_state;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q  <= s_tdata[ByteW-1:0];
      in_start_q <= s_tuser;
    end
    if (advance) begin
      out_byte_q <= scan_res.out_byte;
      out_code_q <= scan_code(scan_res.next_state);
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(TdataOutW-ByteW-CodeW){1'b0}}, out_code_q, out_byte_q};

  `JCB_ASSERT_IMPL(a_stall_only_when_full, !s_tready,
                   in_valid_q && out_valid_q && !m_tready,
                   "Input stalled although a stage is free.")
  `JCB_ASSERT_NEXT(a_code_matches_state, advance,
                   m_tvalid && (out_code_q == scan_code(scan_state_q)),
                   "Output scan code disagrees with the scan state register.")
  `JCB_ASSERT_NEXT(a_held_beat_stays, in_valid_q && !advance,
                   in_valid_q && $stable(in_byte_q) && $stable(in_start_q),
                   "Input register lost or changed a waiting beat.")
  `JCB_ASSERT_IMPL(a_only_blank_changes, in_valid_q && (scan_res.out_byte != in_byte_q),
                   scan_res.out_byte == ChBlank,
                   "A byte was changed to something other than a space.")

endmodule

@@ rtl/jcb_scan.sv @@
module jcb_scan (
  input  logic [7:0]           byte_i,
  input  logic                 start_i,
  input  logic                 nul_ends_i,
  input  jcb_pkg::scan_state_e state_i,
  output jcb_pkg::scan_res_t   res_o
);
  import jcb_pkg::*;

  scan_state_e      st;
  logic [ByteW-1:0] kept;

  assign st   = start_i ? S_PLAIN : state_i;
  assign kept = (byte_i < ChLayout) ? byte_i : ChBlank;

  always_comb begin
    res_o.out_byte   = byte_i;
    res_o.next_state = S_PLAIN;
    if (nul_ends_i && (byte_i == ChNul)) begin
      res_o.next_state = S_PLAIN;
    end else begin
      unique case (st)
        S_STRING: begin
          if (byte_i == ChQuote) res_o.next_state = S_PLAIN;
          else if (byte_i == ChBslash) res_o.next_state = S_ESCAPE;
          else res_o.next_state = S_STRING;
        end
        S_ESCAPE: res_o.next_state = S_STRING;
        S_SLASH: begin
          if (byte_i == ChSlash) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_LINE;
          end else if (byte_i == ChStar) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_BLOCK;
          end else begin
            res_o.next_state = S_PLAIN;
          end
        end
        S_LINE: begin
          if ((byte_i == ChLf) || (byte_i == ChCr)) begin
            res_o.next_state = S_PLAIN;
          end else begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_LINE;
          end
        end
        S_BLOCK: begin
          if (byte_i == ChStar) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_STAR;
          end else begin
            res_o.out_byte   = kept;
            res_o.next_state = S_BLOCK;
          end
        end
        S_STAR: begin
          if (byte_i == ChSlash) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_PLAIN;
          end else if (byte_i == ChStar) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_STAR;
          end else begin
            res_o.out_byte   = kept;
            res_o.next_state = S_BLOCK;
          end
        end
        default: begin
          if (byte_i == ChQuote) begin
            res_o.next_state = S_STRING;
          end else if (byte_i == ChHash) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_LINE;
          end else if (byte_i == ChSlash) begin
            res_o.out_byte   = ChBlank;
            res_o.next_state = S_SLASH;
          end else begin
            res_o.next_state = S_PLAIN;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/jcb_cfg.sv @@
module jcb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jcb_pkg::ApbAddrW-1:0]  paddr,
  input  logic [jcb_pkg::ApbDataW-1:0]  pwdata,
  output logic [jcb_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic                          nul_ends_o
);
  import jcb_pkg::*;

  logic nul_ends_q, nul_ends_d;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[ApbAddrW-1] == RegNulEnds);

  always_comb begin
    nul_ends_d = nul_ends_q;
    if (psel && penable && pwrite && pready && hit) begin
      nul_ends_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nul_ends_q <= 1'b0;
    end else begin
      nul_ends_q <= nul_ends_d;
    end
  end

  assign prdata     = hit ? {{(ApbDataW-1){1'b0}}, nul_ends_q} : '0;
  assign nul_ends_o = nul_ends_q;

endmodule

@@ verif/json_comment_blanker_checker.sv @@
module json_comment_blanker_checker
  import jcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [TdataInW-1:0]   s_tdata,  // [7:0] in_byte
  input  logic                  s_tuser,  // [0] start_of_text
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [TdataOutW-1:0]  m_tdata,  // [7:0] out_byte, [10:8] scan_after
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  input  logic [ApbDataW-1:0]   prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [CodeW-1:0] scan_after;
  } blanked_beat_t;

  blanked_beat_t    expected_beats[$];
  logic [CodeW-1:0] scan_code_q;
  logic             nul_ends_q;
  int               mismatches = 0;

  function automatic logic [ByteW-1:0] keep_layout(logic [ByteW-1:0] c);
    return (c < ChLayout) ? c : ChBlank;
  endfunction

  function automatic blanked_beat_t scan_next(logic [ByteW-1:0] c, logic [CodeW-1:0] st,
                                              logic nul_ends);
    blanked_beat_t r;
    r.out_byte   = c;
    r.scan_after = CodePlain;
    if (!(nul_ends && c == ChNul)) begin
      case (st)
        CodeString: begin
          if (c == ChQuote) r.scan_after = CodePlain;
          else if (c == ChBslash) r.scan_after = CodeEscape;
          else r.scan_after = CodeString;
        end
        CodeEscape: r.scan_after = CodeString;
        CodeSlash: begin
          if (c == ChSlash) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeLine;
          end else if (c == ChStar) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeBlock;
          end
        end
        CodeLine: begin
          if (c != ChLf && c != ChCr) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeLine;
          end
        end
        CodeBlock: begin
          if (c == ChStar) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeStar;
          end else begin
            r.out_byte   = keep_layout(c);
            r.scan_after = CodeBlock;
          end
        end
        CodeStar: begin
          if (c == ChSlash) begin
            r.out_byte   = ChBlank;
          end else if (c == ChStar) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeStar;
          end else begin
            r.out_byte   = keep_layout(c);
            r.scan_after = CodeBlock;
          end
        end
        default: begin
          if (c == ChQuote) begin
            r.scan_after = CodeString;
          end else if (c == ChHash) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeLine;
          end else if (c == ChSlash) begin
            r.out_byte   = ChBlank;
            r.scan_after = CodeSlash;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ApbDataW-1:0] want,
                                 logic [ApbDataW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blanked_beat_t want;
    blanked_beat_t got;
    if (!rst_ni) begin
      scan_code_q = CodePlain;
      nul_ends_q  = 1'b0;
      expected_beats.delete();
      pending_count <= 0;
      fail_count    <= mismatches;
    end else begin
      if (psel && penable && pready && paddr[ApbAddrW-1:2] == RegNulEnds) begin
        if (pwrite) begin
          nul_ends_q = pwdata[0];
        end else if (prdata !== ApbDataW'(nul_ends_q)) begin
          report_mismatch("nul_ends_text readback", ApbDataW'(nul_ends_q), prdata);
        end
      end

      if (s_tvalid && s_tready) begin
        want = scan_next(s_tdata[ByteW-1:0], s_tuser ? CodePlain : scan_code_q, nul_ends_q);
        scan_code_q = want.scan_after;
        expected_beats.push_back(want);
      end

      if (m_tvalid === 1'b1 && m_tready) begin
        got.out_byte   = m_tdata[ByteW-1:0];
        got.scan_after = m_tdata[ByteW+CodeW-1:ByteW];
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with nothing expected", '0, ApbDataW'(m_tdata));
        end else begin
          want = expected_beats.pop_front();
          if (got.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", ApbDataW'(want.out_byte), ApbDataW'(got.out_byte));
          end
          if (got.scan_after !== want.scan_after) begin
            report_mismatch("scan_after", ApbDataW'(want.scan_after),
                            ApbDataW'(got.scan_after));
          end
          if (m_tdata[TdataOutW-1:ByteW+CodeW] !== '0) begin
            report_mismatch("tdata padding", '0, ApbDataW'(m_tdata));
          end
        end
      end

      pending_count <= expected_beats.size();
      fail_count    <= mismatches;
    end
  end

endmodule

@@ verif/json_comment_blanker_tb.sv @@
module json_comment_blanker_tb;
  import jcb_pkg::*;

  localparam logic [ApbAddrW-1:0] AddrNulEnds  = ApbAddrW'({RegNulEnds, 2'b00});
  localparam logic [ApbAddrW-1:0] AddrPastLast = AddrNulEnds + ApbAddrW'(4);
  localparam int BeatsPerPhase = 250;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [TdataInW-1:0]  s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tready = 1'b0;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [ApbAddrW-1:0]  paddr    = '0;
  logic [ApbDataW-1:0]  pwdata   = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [TdataOutW-1:0] m_tdata;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending_count;

  int    tx_idle_pct  = 0;
  int    rx_stall_pct = 0;
  int    beats_sent   = 0;
  string json_chars   = "{}[]:,0123456789-+.eEtrufalsn \t";

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  json_comment_blanker dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  json_comment_blanker_checker checker_i (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .pending_count
  );

  task automatic send_beat(input logic [ByteW-1:0] b, input logic start);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk_i); while (s_tready !== 1'b1);
    beats_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic wait_idle();
    int cycles;
    cycles = 0;
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_count != 0 && cycles < 5000) begin
      @(posedge clk_i);
      cycles++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_nul_ends(input logic value);
    wait_idle();
    apb_access(1'b1, AddrNulEnds, {(ApbDataW-1)'($urandom()), value});
    apb_access(1'b0, AddrNulEnds, '0);
  endtask

  function automatic logic pick_start();
    return ($urandom_range(0, 31) == 0);
  endfunction

  function automatic logic [ByteW-1:0] pick_json_char();
    return json_chars[$urandom_range(0, json_chars.len() - 1)];
  endfunction

  function automatic logic [ByteW-1:0] pick_any_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed JSON pieces with comments, plus some raw noise.
  task automatic send_text_piece();
    int kind;
    int len;
    kind = $urandom_range(0, 19);
    len  = $urandom_range(0, 8);
    if (kind < 5) begin
      repeat (len + 1) send_beat(pick_json_char(), pick_start());
    end else if (kind < 9) begin
      send_beat(ChQuote, pick_start());
      repeat (len) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(ChBslash, pick_start());
          send_beat(pick_any_byte(), pick_start());
        end else if ($urandom_range(0, 1) == 0) begin
          send_beat(pick_json_char(), pick_start());
        end else begin
          send_beat(pick_any_byte(), pick_start());
        end
      end
      send_beat(ChQuote, pick_start());
    end else if (kind < 12) begin
      if ($urandom_range(0, 1) == 0) begin
        send_beat(ChHash, pick_start());
      end else begin
        send_beat(ChSlash, pick_start());
        send_beat(ChSlash, pick_start());
      end
      repeat (len) send_beat(pick_any_byte(), pick_start());
      send_beat($urandom_range(0, 1) ? ChLf : ChCr, pick_start());
    end else if (kind < 16) begin
      send_beat(ChSlash, pick_start());
      send_beat(ChStar, pick_start());
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: send_beat(ChStar, pick_start());
          1: send_beat(ByteW'($urandom_range(0, 32)), pick_start());
          default: send_beat(pick_any_byte(), pick_start());
        endcase
      end
      if ($urandom_range(0, 1) == 0) send_beat(ChStar, pick_start());
      send_beat(ChStar, pick_start());
      send_beat(ChSlash, pick_start());
    end else if (kind == 16) begin
      send_beat(ChSlash, pick_start());
      send_beat(pick_any_byte(), pick_start());
    end else if (kind < 19) begin
      repeat (len + 1) send_beat(pick_any_byte(), pick_start());
    end else begin
      send_beat(ChNul, pick_start());
    end
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, AddrNulEnds, '0);
    send_beat(ChNul, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_str("\"a\\\"x\"");
    send_str("#q\n");
    send_str("//z\r");
    send_str("/* ");
    send_beat(ChNul, 1'b0);
    send_str("*b**/");
    send_str("/\"/#");
    send_str("\"x");
    send_beat("y", 1'b1);

    set_nul_ends(1'b1);
    send_str("\"a");
    send_beat(ChNul, 1'b0);
    send_str("/*");
    send_beat(ChNul, 1'b0);
    send_str("#");
    send_beat(ChNul, 1'b1);

    wait_idle();
    apb_access(1'b1, AddrPastLast, '1);
    apb_access(1'b0, AddrNulEnds, '0);

    for (int phase = 0; phase < 8; phase++) begin
      set_nul_ends(phase >= 4);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
        default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
      endcase
      target = beats_sent + BeatsPerPhase;
      while (beats_sent < target) send_text_piece();
    end

    set_nul_ends(1'b0);
    send_str("/*/ x */\"k\"");
    wait_idle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
